/* sv/unsigned_to_ascii_radix_formatter_defines.svh */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_formatter_defines
// assertion macros shared by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_RADIX_FORMATTER_DEFINES_SVH
`define UNSIGNED_TO_ASCII_RADIX_FORMATTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U2A_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2a assertion failed");

// next-cycle implication, checked outside reset
`define U2A_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2a assertion failed");

`endif

/* sv/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// widths, format codes and character helpers for the radix formatter
// ----------------------------------------------------------------------------
package u2a_pkg;

    localparam int IN_W        = 64;
    localparam int OP_W        = 2;
    localparam int CH_W        = 8;
    localparam int TOT_W       = 5;

    // bits of value that take part in the conversion (8 to 64)
    localparam int VALUE_WIDTH = 64;

    // decimal digits needed: floor(w * log10(2)) + 1
    localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DIG_W       = 4 * DEC_DIGITS;
    localparam int REM_W       = $clog2(DEC_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

    localparam logic [OP_W-1:0] OP_DEC = 2'd0;
    localparam logic [OP_W-1:0] OP_LHEX = 2'd1;
    localparam logic [OP_W-1:0] OP_UHEX = 2'd2;
    localparam logic [OP_W-1:0] OP_PTR = 2'd3;

    localparam logic [2:0] NIL_LAST_IDX = 3'd4;
    localparam logic [TOT_W-1:0] NIL_CHARS = 5'd5;

    function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CH_W-1:0] c;
        begin
            if (d < 4'd10)
                c = 8'h30 + {4'd0, d};
            else if (upper)
                c = 8'h41 + {4'd0, d} - 8'd10;
            else
                c = 8'h61 + {4'd0, d} - 8'd10;
            return c;
        end
    endfunction

    function automatic logic [CH_W-1:0] nil_char(input logic [2:0] idx);
        logic [CH_W-1:0] c;
        begin
            unique case (idx)
                3'd0: c = 8'h28;   // (
                3'd1: c = 8'h6e;   // n
                3'd2: c = 8'h69;   // i
                3'd3: c = 8'h6c;   // l
                3'd4: c = 8'h29;   // )
                default: c = 8'h29;
            endcase
            return c;
        end
    endfunction

endpackage

/* sv/unsigned_to_ascii_radix_formatter.sv */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_formatter
// formats an unsigned value as decimal, hex or pointer ascii, one char a word
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with value and op; one word per number.
// output channel: out_valid / out_stall with ch, last and total_chars; one
// word per character, most significant digit first, last set on the final
// character, where total_chars holds the character count (else 0).
// decimal: value bits are shifted one per cycle into a bcd register
// (shift-and-add-3), then leading zero digits are dropped one per cycle,
// and digits go out one per cycle from the top of the digit register while
// the receiver does not stall.
// hex: no conversion; the value takes the same skip and emit steps.
// pointer first emits "0x". a pointer of zero emits "(nil)" instead.
// in_stall is high from acceptance until the last character sits in the
// output register, so a new number is taken while that character waits.
// a stalled receiver holds the output register and freezes the emit phase.
// reset clears the state machine and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "unsigned_to_ascii_radix_formatter_defines.svh"

module unsigned_to_ascii_radix_formatter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u2a_pkg::IN_W-1:0]    value,
    input  logic [u2a_pkg::OP_W-1:0]    op,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u2a_pkg::CH_W-1:0]    ch,
    output logic                        last,
    output logic [u2a_pkg::TOT_W-1:0]   total_chars
);
    import u2a_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_NIL  = 6'b000010,
        S_PFX  = 6'b000100,
        S_CONV = 6'b001000,
        S_SKIP = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    localparam logic [IN_W-1:0] VALUE_MASK = {IN_W{1'b1}} >> (IN_W - VALUE_WIDTH);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(DEC_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE = REM_W'(1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_WIDTH - 1);

    state_t                 state_reg, state_next;
    logic [DIG_W-1:0]       dig_reg, dig_next;
    logic [VALUE_WIDTH-1:0] src_reg, src_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [2:0]             idx_reg, idx_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [TOT_W-1:0]       nchar_reg, nchar_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic                   last_reg, last_next;
    logic [TOT_W-1:0]       total_reg, total_next;

    logic                   in_accept;
    logic                   out_free;
    logic [IN_W-1:0]        value_masked;
    logic [DIG_W-1:0]       dig_adj;
    logic [3:0]             top_digit;

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign value_masked = value & VALUE_MASK;
    assign top_digit    = dig_reg[DIG_W-1 -: 4];

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            else
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        src_next       = src_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        nchar_next     = nchar_reg;
        out_valid_next = out_valid_reg && out_stall;
        ch_next        = ch_reg;
        last_next      = last_reg;
        total_next     = total_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = op;
                    nchar_next   = '0;
                    idx_next     = '0;
                    bit_cnt_next = '0;
                    rem_next     = REM_FULL;
                    src_next     = value_masked[VALUE_WIDTH-1:0];
                    if (op == OP_DEC)
                    begin
                        dig_next   = '0;
                        state_next = S_CONV;
                    end
                    else
                    begin
                        dig_next = DIG_W'(value_masked);
                        if (op == OP_PTR && value_masked == '0)
                            state_next = S_NIL;
                        else if (op == OP_PTR)
                            state_next = S_PFX;
                        else
                            state_next = S_SKIP;
                    end
                end
            end
            S_NIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ch_next        = nil_char(idx_reg);
                    last_next      = (idx_reg == NIL_LAST_IDX);
                    total_next     = (idx_reg == NIL_LAST_IDX) ? NIL_CHARS : '0;
                    idx_next       = idx_reg + 3'd1;
                    if (idx_reg == NIL_LAST_IDX)
                        state_next = S_IDLE;
                end
            end
            S_PFX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ch_next        = (idx_reg == 3'd0) ? 8'h30 : 8'h78;
                    last_next      = 1'b0;
                    total_next     = '0;
                    nchar_next     = nchar_reg + 5'd1;
                    idx_next       = idx_reg + 3'd1;
                    if (idx_reg != 3'd0)
                        state_next = S_SKIP;
                end
            end
            S_CONV:
            begin
                dig_next     = {dig_adj[DIG_W-2:0], src_reg[VALUE_WIDTH-1]};
                src_next     = {src_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_LAST)
                    state_next = S_SKIP;
            end
            S_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && rem_reg > REM_ONE)
                begin
                    dig_next = {dig_reg[DIG_W-5:0], 4'd0};
                    rem_next = rem_reg - REM_ONE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ch_next        = digit_char(top_digit, op_reg == OP_UHEX);
                    last_next      = (rem_reg == REM_ONE);
                    total_next     = (rem_reg == REM_ONE) ? nchar_reg + 5'd1 : '0;
                    nchar_next     = nchar_reg + 5'd1;
                    dig_next       = {dig_reg[DIG_W-5:0], 4'd0};
                    rem_next       = rem_reg - REM_ONE;
                    if (rem_reg == REM_ONE)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            nchar_reg     <= '0;
            op_reg        <= OP_DEC;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            nchar_reg     <= nchar_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        src_reg   <= src_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        total_reg <= total_next;
    end

    assign out_valid   = out_valid_reg;
    assign ch          = ch_reg;
    assign last        = last_reg;
    assign total_chars = total_reg;

    `U2A_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_reg))
    `U2A_ASSERT_IMP(a_last_count, out_valid_reg && last_reg,
        total_reg != '0 && total_reg <= TOT_W'(DEC_DIGITS))
    `U2A_ASSERT_NXT(a_accept_busy, in_accept, state_reg != S_IDLE)
    `U2A_ASSERT_NXT(a_emit_done, state_reg == S_EMIT && out_free && rem_reg == REM_ONE,
        state_reg == S_IDLE && out_valid_reg && last_reg)

endmodule
